FILE: rtl/tdd_pkg.sv
// Package: shared constants, command codes and state type of the task dispatcher.
`default_nettype none
package tdd_pkg;

    localparam int MAX_TASKS_DEF = 32;
    localparam int MAX_EDGES_DEF = 128;

    // Command codes
    localparam logic [3:0] CMD_CLEAR    = 4'd0;
    localparam logic [3:0] CMD_SUBMIT   = 4'd1;
    localparam logic [3:0] CMD_ADD_EDGE = 4'd2;
    localparam logic [3:0] CMD_ADD_REF  = 4'd3;
    localparam logic [3:0] CMD_DROP_REF = 4'd4;
    localparam logic [3:0] CMD_START    = 4'd5;
    localparam logic [3:0] CMD_COMPLETE = 4'd6;
    localparam logic [3:0] CMD_BIND     = 4'd7;
    localparam logic [3:0] CMD_QUERY    = 4'd8;

    // Task kinds held in the task table
    localparam logic [1:0] KIND_RUN  = 2'd0;
    localparam logic [1:0] KIND_HOLD = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Result kinds
    localparam logic [1:0] RES_ACK   = 2'd0;
    localparam logic [1:0] RES_READY = 2'd1;
    localparam logic [1:0] RES_COUNT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_CMD_A,
        S_AE_LINK,
        S_AE_B,
        S_SC_RD,
        S_SC_W,
        S_SD_RD,
        S_SD,
        S_DRAIN,
        S_EDGE,
        S_DEC,
        S_POP,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/tdd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module tdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/task_dependency_dispatcher_unit.sv
// Top level: dependency-counting task dispatcher with memory-based task and edge tables.
`default_nettype none
// Usage:
//   A command transfer happens at a rising edge with start high and busy low.
//   busy stays high until the closing result is shown. Results appear
//   on the o_ result ports for one cycle each, marked by o_valid; the receiver
//   must take them as they come and cannot stall the block.
//   Every command gives zero or more ready results (result kind 1) and then
//   one closing result with o_last high (acknowledge, or count report on
//   query).
// Steps:
//   Clear, submit and unknown codes go straight to the closing result. Add ref,
//   bind and query read task a and then act on it. Add edge also links the new
//   edge and raises the count of the waiting task. Drop ref and complete walk
//   the successor edges of each resolved list. Start scans the counts of all
//   tasks, then visits each task once more and dispatches every ready task.
//   One command is worked at a time.
// Reset:
//   Synchronous, active low; clears task, edge and pending counts. Table
//   entries are written before they are read, so no clearing pass is run.
module task_dependency_dispatcher_unit #(
    parameter int MAX_TASKS = tdd_pkg::MAX_TASKS_DEF,
    parameter int MAX_EDGES = tdd_pkg::MAX_EDGES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [3:0] i_command,
    input  wire logic [4:0] i_first_task,
    input  wire logic [4:0] i_second_task,
    input  wire logic       i_task_kind,
    output logic            o_valid,
    output logic [1:0]      o_result_kind,
    output logic [4:0]      o_task_id,
    output logic [7:0]      o_ref_count,
    output logic [5:0]      o_pending_tasks,
    output logic            o_dup_dispatch,
    output logic            o_table_full,
    output logic            o_last
);

    import tdd_pkg::*;

    localparam int TW   = $clog2(MAX_TASKS);
    localparam int IW   = (TW > 5) ? TW : 5;
    localparam int CNTW = $clog2(MAX_TASKS + 1);
    localparam int EW   = $clog2(MAX_EDGES);
    localparam int PW   = EW + 1;
    localparam int SPW  = $clog2(MAX_TASKS + 2);
    localparam int ENTW = 10 + 2 * PW;
    localparam int FRW  = TW + PW + 1;
    localparam logic [PW-1:0] NO_EDGE = PW'(MAX_EDGES);

    // Control and payload registers
    t_state            r_state, n_state;
    logic [3:0]        r_cmd, n_cmd;
    logic [IW-1:0]     r_a, n_a;
    logic [IW-1:0]     r_b, n_b;
    logic              r_kind, n_kind;
    logic [IW-1:0]     r_id, n_id;
    logic [7:0]        r_refc, n_refc;
    logic              r_dup, n_dup;
    logic              r_full, n_full;
    logic [CNTW-1:0]   r_ttot, n_ttot;
    logic [PW-1:0]     r_etot, n_etot;
    logic [CNTW-1:0]   r_pend, n_pend;
    logic [CNTW-1:0]   r_idx, n_idx;
    logic [MAX_TASKS-1:0] r_ready, n_ready;
    logic [TW-1:0]     r_s, n_s;
    logic [PW-1:0]     r_tail, n_tail;
    logic [TW-1:0]     r_ft, n_ft;
    logic [PW-1:0]     r_fc, n_fc;
    logic              r_fm, n_fm;
    logic [SPW-1:0]    r_sp, n_sp;

    // Output registers
    logic              r_ov, n_ov;
    logic [1:0]        r_okind, n_okind;
    logic [IW-1:0]     r_oid, n_oid;
    logic [7:0]        r_orefc, n_orefc;
    logic [CNTW-1:0]   r_opend, n_opend;
    logic              r_odup, n_odup;
    logic              r_ofull, n_ofull;
    logic              r_olast, n_olast;

    // Memory ports
    logic              task_we;
    logic [TW-1:0]     task_wa, task_ra;
    logic [ENTW-1:0]   task_wd, task_rd;
    logic              tgt_we;
    logic [EW-1:0]     tgt_wa;
    logic [TW-1:0]     tgt_wd, tgt_rd;
    logic              nxt_we;
    logic [EW-1:0]     nxt_wa;
    logic [PW-1:0]     nxt_wd, nxt_rd;
    logic              stk_we;
    logic [TW-1:0]     stk_wa, stk_ra;
    logic [FRW-1:0]    stk_wd, stk_rd;

    // Decoded task entry and helpers
    logic [1:0]        d_state;
    logic [7:0]        d_refs;
    logic [PW-1:0]     d_head, d_tail;
    logic [7:0]        refs_inc;
    logic [IW-1:0]     in_a, in_b;
    logic              in_a_ok, in_b_ok;
    logic              cur_end;
    logic              tgt_bad;
    logic              do_disp;
    logic [7:0]        w_refs;
    logic [SPW-1:0]    sp_m1, sp_m2;

    assign d_state  = task_rd[ENTW-1 -: 2];
    assign d_refs   = task_rd[ENTW-3 -: 8];
    assign d_head   = task_rd[2*PW-1 -: PW];
    assign d_tail   = task_rd[PW-1:0];
    assign refs_inc = (d_refs == 8'hFF) ? d_refs : d_refs + 8'd1;
    assign in_a     = IW'(i_first_task);
    assign in_b     = IW'(i_second_task);
    assign in_a_ok  = (IW+1)'(in_a) < (IW+1)'(r_ttot);
    assign in_b_ok  = (IW+1)'(in_b) < (IW+1)'(r_ttot);
    assign cur_end  = (r_fc >= NO_EDGE) || (r_fc >= r_etot);
    assign tgt_bad  = (CNTW+1)'(tgt_rd) >= (CNTW+1)'(r_ttot);
    assign sp_m1    = r_sp - SPW'(1);
    assign sp_m2    = r_sp - SPW'(2);

    // Task table: kind, count, successor head and tail
    tdd_ram #(.WIDTH(ENTW), .DEPTH(MAX_TASKS)) u_task (
        .i_clk(i_clk), .i_we(task_we), .i_waddr(task_wa), .i_wdata(task_wd),
        .i_raddr(task_ra), .o_rdata(task_rd)
    );

    // Edge table split into target and next-link memories
    tdd_ram #(.WIDTH(TW), .DEPTH(MAX_EDGES)) u_tgt (
        .i_clk(i_clk), .i_we(tgt_we), .i_waddr(tgt_wa), .i_wdata(tgt_wd),
        .i_raddr(r_fc[EW-1:0]), .o_rdata(tgt_rd)
    );

    tdd_ram #(.WIDTH(PW), .DEPTH(MAX_EDGES)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(r_fc[EW-1:0]), .o_rdata(nxt_rd)
    );

    // Resolve stack: frames below the top one, which sits in registers
    tdd_ram #(.WIDTH(FRW), .DEPTH(MAX_TASKS)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_wa), .i_wdata(stk_wd),
        .i_raddr(stk_ra), .o_rdata(stk_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_command)
                        CMD_ADD_EDGE: begin
                            if (in_a_ok && in_b_ok && r_etot < PW'(MAX_EDGES)) begin
                                n_state = S_RD_A;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        CMD_ADD_REF, CMD_DROP_REF, CMD_COMPLETE, CMD_BIND, CMD_QUERY: begin
                            n_state = in_a_ok ? S_RD_A : S_FINISH;
                        end
                        CMD_START: n_state = (r_pend != '0) ? S_SC_RD : S_FINISH;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_RD_A:    n_state = (r_cmd == CMD_DROP_REF) ? S_DEC : S_CMD_A;
            S_CMD_A: begin
                if (r_cmd == CMD_ADD_EDGE) begin
                    n_state = S_AE_LINK;
                end else if (r_cmd == CMD_COMPLETE) begin
                    n_state = S_DRAIN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_AE_LINK: n_state = S_AE_B;
            S_AE_B:    n_state = S_FINISH;
            S_SC_RD:   n_state = (r_idx >= r_ttot) ? S_SD_RD : S_SC_W;
            S_SC_W:    n_state = S_SC_RD;
            S_SD_RD: begin
                if (r_idx >= r_ttot) begin
                    n_state = S_FINISH;
                end else if (r_ready[r_idx[TW-1:0]]) begin
                    n_state = S_SD;
                end
            end
            S_SD:      n_state = S_DRAIN;
            S_DRAIN: begin
                if (r_sp == '0) begin
                    n_state = (r_cmd == CMD_START) ? S_SD_RD : S_FINISH;
                end else if (cur_end) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE:    n_state = tgt_bad ? S_DRAIN : S_DEC;
            S_DEC:     n_state = S_DRAIN;
            S_POP:     n_state = S_DRAIN;
            S_FINISH:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, memory ports and results
    always_comb begin
        n_cmd = r_cmd;   n_a = r_a;       n_b = r_b;       n_kind = r_kind;
        n_id = r_id;     n_refc = r_refc; n_dup = r_dup;   n_full = r_full;
        n_ttot = r_ttot; n_etot = r_etot; n_pend = r_pend; n_idx = r_idx;
        n_ready = r_ready; n_s = r_s;     n_tail = r_tail;
        n_ft = r_ft;     n_fc = r_fc;     n_fm = r_fm;     n_sp = r_sp;
        n_ov = 1'b0;     n_okind = r_okind; n_oid = r_oid; n_orefc = r_orefc;
        n_opend = r_opend; n_odup = r_odup; n_ofull = r_ofull; n_olast = r_olast;
        task_we = 1'b0;  task_wa = r_s;   task_wd = task_rd; task_ra = r_a[TW-1:0];
        tgt_we = 1'b0;   tgt_wa = r_etot[EW-1:0]; tgt_wd = r_b[TW-1:0];
        nxt_we = 1'b0;   nxt_wa = r_etot[EW-1:0]; nxt_wd = NO_EDGE;
        stk_we = 1'b0;   stk_wa = sp_m1[TW-1:0];  stk_wd = {r_ft, r_fc, r_fm};
        stk_ra = sp_m2[TW-1:0];
        do_disp = 1'b0;  w_refs = d_refs;

        case (r_state)
            // Command transfer
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_command; n_a = in_a; n_b = in_b; n_kind = i_task_kind;
                    n_id = in_a; n_refc = 8'd0; n_dup = 1'b0; n_full = 1'b0;
                    n_s = in_a[TW-1:0];
                    n_idx = '0;
                    case (i_command)
                        CMD_CLEAR: begin
                            n_ttot = '0; n_etot = '0; n_pend = '0;
                        end
                        CMD_SUBMIT: begin
                            if (r_ttot >= CNTW'(MAX_TASKS)) begin
                                n_full = 1'b1;
                                n_id = '0;
                            end else begin
                                task_we = 1'b1;
                                task_wa = r_ttot[TW-1:0];
                                task_wd = {1'b0, i_task_kind, 8'd1, NO_EDGE, NO_EDGE};
                                n_id = IW'(r_ttot);
                                n_ttot = r_ttot + CNTW'(1);
                                n_pend = r_pend + CNTW'(1);
                            end
                        end
                        CMD_ADD_EDGE: begin
                            if (in_a_ok && in_b_ok && r_etot >= PW'(MAX_EDGES)) begin
                                n_full = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Single-entry commands on task a
            S_CMD_A: begin
                task_wa = r_a[TW-1:0];
                case (r_cmd)
                    CMD_ADD_EDGE: begin
                        task_we = 1'b1;
                        task_wd = {d_state, d_refs,
                                   (d_tail == NO_EDGE) ? r_etot : d_head, r_etot};
                        n_tail = d_tail;
                        tgt_we = 1'b1;
                        nxt_we = 1'b1;
                    end
                    CMD_ADD_REF: begin
                        task_we = 1'b1;
                        task_wd = {d_state, refs_inc, d_head, d_tail};
                    end
                    CMD_BIND: begin
                        if (d_state == KIND_HOLD) begin
                            task_we = 1'b1;
                            task_wd = {1'b0, r_kind, d_refs, d_head, d_tail};
                        end
                    end
                    CMD_QUERY: n_refc = d_refs;
                    CMD_COMPLETE: begin
                        n_ft = r_a[TW-1:0];
                        n_fc = d_head;
                        n_fm = 1'b0;
                        n_sp = SPW'(1);
                    end
                    default: ;
                endcase
            end
            // Link the new edge behind the old tail and read the waiting task
            S_AE_LINK: begin
                task_ra = r_b[TW-1:0];
                if (r_tail != NO_EDGE) begin
                    nxt_we = 1'b1;
                    nxt_wa = r_tail[EW-1:0];
                    nxt_wd = r_etot;
                end
            end
            S_AE_B: begin
                task_we = 1'b1;
                task_wa = r_b[TW-1:0];
                task_wd = {d_state, refs_inc, d_head, d_tail};
                n_etot = r_etot + PW'(1);
            end
            // Start, first pass: lower every live count
            S_SC_RD: begin
                task_ra = r_idx[TW-1:0];
                if (r_idx >= r_ttot) begin
                    n_idx = '0;
                end
            end
            S_SC_W: begin
                n_ready[r_idx[TW-1:0]] = 1'b0;
                if (d_state != KIND_DONE && d_refs != 8'd0) begin
                    task_we = 1'b1;
                    task_wa = r_idx[TW-1:0];
                    task_wd = {d_state, d_refs - 8'd1, d_head, d_tail};
                    n_ready[r_idx[TW-1:0]] = (d_refs == 8'd1);
                end
                n_idx = r_idx + CNTW'(1);
            end
            // Start, second pass: dispatch tasks that reached zero
            S_SD_RD: begin
                task_ra = r_idx[TW-1:0];
                n_s = r_idx[TW-1:0];
                if (r_idx < r_ttot && !r_ready[r_idx[TW-1:0]]) begin
                    n_idx = r_idx + CNTW'(1);
                end
            end
            S_SD: begin
                task_we = 1'b1;
                task_wd = {d_state, d_refs, d_head, d_tail};
                do_disp = 1'b1;
            end
            // Walk step: read the next edge or pop the finished frame
            S_DRAIN: begin
                task_ra = r_ft;
                if (r_sp == '0 && r_cmd == CMD_START) begin
                    n_idx = r_idx + CNTW'(1);
                end
            end
            S_EDGE: begin
                task_ra = tgt_rd;
                n_s = tgt_rd;
                n_fc = nxt_rd;
            end
            S_DEC: begin
                if (d_refs != 8'd0) begin
                    w_refs = d_refs - 8'd1;
                    task_we = 1'b1;
                    task_wd = {d_state, w_refs, d_head, d_tail};
                    do_disp = (d_refs == 8'd1);
                end
            end
            S_POP: begin
                if (r_pend != '0) begin
                    n_pend = r_pend - CNTW'(1);
                end
                if (r_fm) begin
                    task_we = 1'b1;
                    task_wa = r_ft;
                    task_wd = {KIND_DONE, d_refs, d_head, d_tail};
                end
                n_sp = sp_m1;
                if (r_sp > SPW'(1)) begin
                    {n_ft, n_fc, n_fm} = stk_rd;
                end
            end
            // Closing result
            S_FINISH: begin
                n_ov = 1'b1;
                n_okind = (r_cmd == CMD_QUERY) ? RES_COUNT : RES_ACK;
                n_oid = r_id;
                n_orefc = r_refc;
                n_opend = r_pend;
                n_odup = r_dup;
                n_ofull = r_full;
                n_olast = 1'b1;
            end
            default: ;
        endcase

        // Dispatch of task r_s whose count reached zero
        if (do_disp) begin
            if (d_state == KIND_DONE) begin
                n_dup = 1'b1;
            end else if (d_state == KIND_RUN) begin
                task_wd = {KIND_DONE, w_refs, d_head, d_tail};
                n_ov = 1'b1;
                n_okind = RES_READY;
                n_oid = IW'(r_s);
                n_orefc = 8'd0;
                n_opend = r_pend;
                n_odup = 1'b0;
                n_ofull = 1'b0;
                n_olast = 1'b0;
            end else begin
                stk_we = (r_sp != '0);
                n_ft = r_s;
                n_fc = d_head;
                n_fm = 1'b1;
                n_sp = r_sp + SPW'(1);
            end
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ttot  <= '0;
            r_etot  <= '0;
            r_pend  <= '0;
            r_sp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ttot  <= n_ttot;
            r_etot  <= n_etot;
            r_pend  <= n_pend;
            r_sp    <= n_sp;
            r_ov    <= n_ov;
        end
        r_cmd <= n_cmd;   r_a <= n_a;       r_b <= n_b;       r_kind <= n_kind;
        r_id <= n_id;     r_refc <= n_refc; r_dup <= n_dup;   r_full <= n_full;
        r_idx <= n_idx;   r_ready <= n_ready; r_s <= n_s;     r_tail <= n_tail;
        r_ft <= n_ft;     r_fc <= n_fc;     r_fm <= n_fm;
        r_okind <= n_okind; r_oid <= n_oid; r_orefc <= n_orefc; r_opend <= n_opend;
        r_odup <= n_odup; r_ofull <= n_ofull; r_olast <= n_olast;
    end

    // Ports
    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_ov;
    assign o_result_kind   = r_okind;
    assign o_task_id       = r_oid[4:0];
    assign o_ref_count     = r_orefc;
    assign o_pending_tasks = 6'(r_opend);
    assign o_dup_dispatch  = r_odup;
    assign o_table_full    = r_ofull;
    assign o_last          = r_olast;

endmodule
`default_nettype wire
